/* sv/atl1_pkg.sv */
package atl1_pkg;

  // decode_mode codes
  localparam logic [3:0] MODE_PLAIN  = 4'd0;
  localparam logic [3:0] MODE_ACCENT = 4'd1;
  localparam logic [3:0] MODE_GRAVE  = 4'd2;
  localparam logic [3:0] MODE_ACUTE  = 4'd3;
  localparam logic [3:0] MODE_CIRC   = 4'd4;
  localparam logic [3:0] MODE_DIAER  = 4'd5;
  localparam logic [3:0] MODE_CEDIL  = 4'd6;
  localparam logic [3:0] MODE_ESC    = 4'd7;
  localparam logic [3:0] MODE_CUR1   = 4'd8;
  localparam logic [3:0] MODE_CUR2   = 4'd9;

  // lead and special bytes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ACCENT = 8'h16;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CURSOR = 8'h1F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // outcome of decoding one byte
  typedef struct packed {
    logic [1:0] cnt;        // results caused: 0, 1 or 2
    logic [7:0] b0;
    logic [7:0] b1;
    logic       end_mark;
    logic [3:0] mode_next;
  } dec_t;

  function automatic logic [7:0] plain_byte(input logic [7:0] b);
    logic [7:0] r;
    if (b == CH_BQUOTE) r = 8'hAD;
    else if (b == CH_TILDE) r = 8'hAF;
    else if (b == CH_DEL) r = CH_SPACE;
    else if (b >= CH_SPACE && b[7] == 1'b0) r = b;
    else r = CH_QMARK;
    return r;
  endfunction

  // lowercase accented vowel; accent: grave, acute, circ, diaeresis
  function automatic logic [7:0] vowel_tab(input logic [1:0] acc, input logic [2:0] v);
    logic [7:0] r;
    r = 8'h00;
    case ({acc, v})
      {2'd0, 3'd0}: r = 8'hE0;
      {2'd0, 3'd1}: r = 8'hE8;
      {2'd0, 3'd2}: r = 8'hEC;
      {2'd0, 3'd3}: r = 8'hF2;
      {2'd0, 3'd4}: r = 8'hF9;
      {2'd1, 3'd0}: r = 8'hE1;
      {2'd1, 3'd1}: r = 8'hE9;
      {2'd1, 3'd2}: r = 8'hED;
      {2'd1, 3'd3}: r = 8'hF3;
      {2'd1, 3'd4}: r = 8'hFA;
      {2'd2, 3'd0}: r = 8'hE2;
      {2'd2, 3'd1}: r = 8'hEA;
      {2'd2, 3'd2}: r = 8'hEE;
      {2'd2, 3'd3}: r = 8'hF4;
      {2'd2, 3'd4}: r = 8'hFB;
      {2'd3, 3'd0}: r = 8'hE4;
      {2'd3, 3'd1}: r = 8'hEB;
      {2'd3, 3'd2}: r = 8'hEF;
      {2'd3, 3'd3}: r = 8'hF6;
      {2'd3, 3'd4}: r = 8'hFC;
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic dec_t one_res(input logic [7:0] b);
    dec_t d;
    d.cnt       = 2'd1;
    d.b0        = b;
    d.b1        = 8'h00;
    d.end_mark  = 1'b0;
    d.mode_next = MODE_PLAIN;
    return d;
  endfunction

  function automatic dec_t two_res(input logic [7:0] a, input logic [7:0] b);
    dec_t d;
    d.cnt       = 2'd2;
    d.b0        = a;
    d.b1        = b;
    d.end_mark  = 1'b0;
    d.mode_next = MODE_PLAIN;
    return d;
  endfunction

  function automatic dec_t no_res(input logic [3:0] m);
    dec_t d;
    d.cnt       = 2'd0;
    d.b0        = 8'h00;
    d.b1        = 8'h00;
    d.end_mark  = 1'b0;
    d.mode_next = m;
    return d;
  endfunction

  // byte after the 0x16 lead
  function automatic dec_t accent_code(input logic [7:0] b);
    dec_t d;
    case (b)
      8'h41:   d = no_res(MODE_GRAVE);    // 'A'
      8'h42:   d = no_res(MODE_ACUTE);    // 'B'
      8'h43:   d = no_res(MODE_CIRC);     // 'C'
      8'h48:   d = no_res(MODE_DIAER);    // 'H'
      8'h4B:   d = no_res(MODE_CEDIL);    // 'K'
      8'h23:   d = one_res(8'hA3);
      8'h24:   d = one_res(8'h24);
      8'h26:   d = one_res(8'h23);
      8'h2C:   d = two_res(8'h3C, 8'h2D); // "<-"
      8'h2D:   d = one_res(8'h5E);
      8'h2E:   d = two_res(8'h2D, 8'h3E); // "->"
      8'h2F:   d = one_res(8'h56);
      8'h30:   d = one_res(8'hB0);
      8'h31:   d = one_res(8'hB1);
      8'h38:   d = one_res(8'hF7);
      8'h3C:   d = one_res(8'hBC);
      8'h3D:   d = one_res(8'hBD);
      8'h3E:   d = one_res(8'hBE);
      8'h6A:   d = two_res(8'h4F, 8'h45); // "OE"
      8'h7A:   d = two_res(8'h6F, 8'h65); // "oe"
      8'h7B:   d = one_res(8'hDF);
      8'h27:   d = one_res(8'hA7);
      default: d = no_res(MODE_PLAIN);    // unknown code is swallowed
    endcase
    return d;
  endfunction

  // byte after an accent prefix
  function automatic dec_t accent_letter(input logic [3:0] m, input logic [7:0] b);
    dec_t       d;
    logic [1:0] acc;
    acc = 2'(m - MODE_GRAVE);
    if (m == MODE_CEDIL) begin
      if (b == 8'h63) d = one_res(8'hE7);
      else if (b == 8'h43) d = one_res(8'hC7);
      else d = one_res(plain_byte(b));
    end else begin
      case (b)
        8'h61:   d = one_res(vowel_tab(acc, 3'd0));
        8'h65:   d = one_res(vowel_tab(acc, 3'd1));
        8'h69:   d = one_res(vowel_tab(acc, 3'd2));
        8'h6F:   d = one_res(vowel_tab(acc, 3'd3));
        8'h75:   d = one_res(vowel_tab(acc, 3'd4));
        8'h41:   d = one_res(vowel_tab(acc, 3'd0) - 8'h20);
        8'h45:   d = one_res(vowel_tab(acc, 3'd1) - 8'h20);
        8'h49:   d = one_res(vowel_tab(acc, 3'd2) - 8'h20);
        8'h4F:   d = one_res(vowel_tab(acc, 3'd3) - 8'h20);
        8'h55:   d = one_res(vowel_tab(acc, 3'd4) - 8'h20);
        default: d = one_res(plain_byte(b));
      endcase
    end
    return d;
  endfunction

  function automatic dec_t decode(input logic [3:0] m, input logic [7:0] b);
    dec_t d;
    if (b == CH_NUL) begin
      d          = one_res(8'h00);
      d.end_mark = 1'b1;
    end else begin
      case (m)
        MODE_ACCENT: d = accent_code(b);
        MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_DIAER, MODE_CEDIL:
          d = accent_letter(m, b);
        MODE_ESC:
          d = no_res((b == CH_SPACE || b == CH_HASH) ? MODE_ESC : MODE_PLAIN);
        MODE_CUR1:   d = no_res(MODE_CUR2);
        MODE_CUR2:   d = no_res(MODE_PLAIN);
        default: begin
          if (b == CH_ACCENT) d = no_res(MODE_ACCENT);
          else if (b == CH_ESC) d = no_res(MODE_ESC);
          else if (b == CH_CURSOR) d = no_res(MODE_CUR1);
          else d = one_res(plain_byte(b));
        end
      endcase
    end
    return d;
  endfunction

endpackage

/* sv/accent_text_to_latin1_unit.sv */
// Terminal text to Latin-1 converter. One source byte per input transaction
// on char_code; each byte yields zero, one or two output transactions of
// out_byte, with run_last marking the final one a byte caused and text_end
// marking the zero-byte terminator (out_byte 0). Accent (0x16), escape
// (0x1B) and cursor (0x1F) sequences are tracked in a 4-bit mode register.
// Timing: a byte sits in an input register, is decoded and lands in the
// output register; the block takes one byte per cycle unless stalled. The
// only internal stall is the two-byte expansions (arrows, OE/oe): the second
// byte is held in a pending register and drained once the output register
// is free, while the input stage waits. Downstream backpressure stalls
// through the output register.
module accent_text_to_latin1_unit
  import atl1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_end
);

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;

  // decoder state
  logic [3:0] mode;

  // second byte of an expansion, waiting for the output register
  logic       pend_valid;
  logic [7:0] pend_byte;

  dec_t dec;
  logic out_free;
  logic fire;

  assign dec      = decode(mode, s1_byte);
  assign out_free = !out_valid || out_ready;

  // a byte leaves the input stage once nothing is pending and, if it makes
  // output, the output register can take it
  assign fire     = s1_valid && !pend_valid && (dec.cnt == 2'd0 || out_free);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      mode       <= MODE_PLAIN;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end

      if (pend_valid && out_free) begin
        // drain second half of an expansion
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (fire && dec.cnt != 2'd0) begin
        mode       <= dec.mode_next;
        out_valid  <= 1'b1;
        pend_valid <= (dec.cnt == 2'd2);
      end else begin
        if (fire) begin
          mode <= dec.mode_next;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= char_code;
    end
    if (pend_valid && out_free) begin
      out_byte <= pend_byte;
      run_last <= 1'b1;
      text_end <= 1'b0;
    end else if (fire && dec.cnt != 2'd0) begin
      out_byte  <= dec.b0;
      run_last  <= (dec.cnt == 2'd1);
      text_end  <= dec.end_mark;
      pend_byte <= dec.b1;
    end
  end

endmodule

/* tb/sv/accent_text_to_latin1_unit_test.sv */
module accent_text_to_latin1_unit_test
  import atl1_pkg::*;
();

  localparam int RAND_ITEMS   = 1000;  // bytes in the random part
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 8;     // leave room for strays

  // One source byte plus, for directed rows, an expectation typed in by hand.
  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic [7:0] exp_ch;
    logic       exp_end;
  } feed_t;

  // One output transaction.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       term;
  } latin_out_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;

  // Directed opening. TYPED rows carry the only result they cause; PRED rows
  // go through the predictor like the random stream does.
  localparam int OPENING_ROWS = 30;
  localparam logic [0:OPENING_ROWS-1][17:0] OPENING = {
    {"A",        TYPED, "A",      1'b0},  // printable byte passes through
    {CH_BQUOTE,  TYPED, 8'hAD,    1'b0},  // remapped bytes
    {CH_TILDE,   TYPED, 8'hAF,    1'b0},
    {CH_DEL,     TYPED, CH_SPACE, 1'b0},
    {8'h01,      TYPED, CH_QMARK, 1'b0},  // lowest control byte
    {8'h80,      TYPED, CH_QMARK, 1'b0},  // high half
    {8'hFF,      TYPED, CH_QMARK, 1'b0},
    {CH_NUL,     TYPED, 8'h00,    1'b1},  // text end from plain mode
    {CH_ACCENT,  PRED,  8'h00,    1'b0},  // left arrow: two results
    {",",        PRED,  8'h00,    1'b0},
    {CH_ACCENT,  PRED,  8'h00,    1'b0},  // grave e
    {"A",        PRED,  8'h00,    1'b0},
    {"e",        PRED,  8'h00,    1'b0},
    {CH_ACCENT,  PRED,  8'h00,    1'b0},  // cedilla on capital C
    {"K",        PRED,  8'h00,    1'b0},
    {"C",        PRED,  8'h00,    1'b0},
    {CH_ACCENT,  PRED,  8'h00,    1'b0},  // diaeresis with a lead byte after it
    {"H",        PRED,  8'h00,    1'b0},
    {CH_ESC,     TYPED, CH_QMARK, 1'b0},
    {CH_ACCENT,  PRED,  8'h00,    1'b0},  // unknown accent code is swallowed
    {"Z",        PRED,  8'h00,    1'b0},
    {CH_ESC,     PRED,  8'h00,    1'b0},  // escape: blank and # stay, next byte ends it
    {CH_SPACE,   PRED,  8'h00,    1'b0},
    {CH_HASH,    PRED,  8'h00,    1'b0},
    {"x",        PRED,  8'h00,    1'b0},
    {CH_CURSOR,  PRED,  8'h00,    1'b0},  // cursor: two bytes skipped
    {"a",        PRED,  8'h00,    1'b0},
    {"b",        PRED,  8'h00,    1'b0},
    {CH_ACCENT,  PRED,  8'h00,    1'b0},  // text end in the middle of a sequence
    {CH_NUL,     TYPED, 8'h00,    1'b1}
  };

  // Codes that follow the accent lead; the first five are accent prefixes.
  localparam logic [0:21][7:0] ACCENT_CODES = {
    "A", "B", "C", "H", "K", "#", "$", "&", ",", "-", ".",
    "/", "0", "1", "8", "<", "=", ">", "j", "z", "{", "'"
  };
  localparam logic [0:11][7:0] LETTERS = "aeiouAEIOUcC";
  localparam logic [0:4][7:0]  VOWELS  = "aeiou";

  // Lowercase accented vowels, rows grave/acute/circumflex/diaeresis.
  localparam logic [0:3][0:4][7:0] ACC_VOWEL = {
    8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9,
    8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA,
    8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB,
    8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  feed_t      text_q[$];      // bytes still to send
  feed_t      cur_row = '0;   // row currently on char_code
  latin_out_t latin_due[$];   // results owed by the block, oldest first
  logic [3:0] tr_mode = MODE_PLAIN;  // predictor's copy of the decode mode
  int         errors = 0;
  int         quiet_cycles = 0;

  accent_text_to_latin1_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [7:0] plain_map(input logic [7:0] b);
    if (b == CH_BQUOTE) return 8'hAD;
    if (b == CH_TILDE) return 8'hAF;
    if (b == CH_DEL) return CH_SPACE;
    if (b >= CH_SPACE && !b[7]) return b;
    return CH_QMARK;
  endfunction

  // Converts one byte, advancing tr_mode. Returns the number of results
  // (0..2) with their bytes in o0, o1. No result byte is ever zero except
  // the text-end marker.
  function automatic int to_latin1(input logic [7:0] b, output logic [7:0] o0,
                                   output logic [7:0] o1);
    int         n;
    logic [7:0] lc;
    n  = 0;
    o0 = 8'h00;
    o1 = 8'h00;
    lc = b | 8'h20;  // folds the case of letters
    if (b == CH_NUL) begin
      tr_mode = MODE_PLAIN;
      n = 1;
    end else begin
      case (tr_mode)
        MODE_ACCENT: begin
          tr_mode = MODE_PLAIN;
          case (b)
            "A": tr_mode = MODE_GRAVE;
            "B": tr_mode = MODE_ACUTE;
            "C": tr_mode = MODE_CIRC;
            "H": tr_mode = MODE_DIAER;
            "K": tr_mode = MODE_CEDIL;
            "#": o0 = 8'hA3;
            "$": o0 = "$";
            "&": o0 = "#";
            ",": {o0, o1} = "<-";
            "-": o0 = "^";
            ".": {o0, o1} = "->";
            "/": o0 = "V";
            "0": o0 = 8'hB0;
            "1": o0 = 8'hB1;
            "8": o0 = 8'hF7;
            "<": o0 = 8'hBC;
            "=": o0 = 8'hBD;
            ">": o0 = 8'hBE;
            "j": {o0, o1} = "OE";
            "z": {o0, o1} = "oe";
            "{": o0 = 8'hDF;
            "'": o0 = 8'hA7;
            default: ;  // unknown code: swallowed
          endcase
          n = int'(o0 != 8'h00) + int'(o1 != 8'h00);
        end
        MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_DIAER, MODE_CEDIL: begin
          // no matching letter: the byte is handled as plain
          o0 = plain_map(b);
          if (tr_mode == MODE_CEDIL) begin
            if (lc == "c") o0 = b[5] ? 8'hE7 : 8'hC7;
          end else begin
            for (int v = 0; v < 5; v++)
              if (lc == VOWELS[v])
                o0 = ACC_VOWEL[2'(tr_mode - MODE_GRAVE)][v] - (b[5] ? 8'h00 : 8'h20);
          end
          tr_mode = MODE_PLAIN;
          n = 1;
        end
        MODE_ESC: begin
          if (b != CH_SPACE && b != CH_HASH) tr_mode = MODE_PLAIN;
        end
        MODE_CUR1: tr_mode = MODE_CUR2;
        MODE_CUR2: tr_mode = MODE_PLAIN;
        default: begin
          case (b)
            CH_ACCENT: tr_mode = MODE_ACCENT;
            CH_ESC:    tr_mode = MODE_ESC;
            CH_CURSOR: tr_mode = MODE_CUR1;
            default: begin
              tr_mode = MODE_PLAIN;
              o0 = plain_map(b);
              n = 1;
            end
          endcase
        end
      endcase
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] b);
    text_q.push_back({b, PRED, 8'h00, 1'b0});
  endfunction

  // Mostly well-formed sequences with random content; the rest is noise.
  // Every byte queued counts, escape and cursor runs included.
  task automatic queue_random_text(input int want);
    int         base;
    int         pick;
    logic [7:0] code;
    base = text_q.size();
    while (text_q.size() - base < want) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        add_byte(8'($urandom_range(1, 255)));
      end else if (pick < 65) begin
        add_byte(CH_ACCENT);
        code = ($urandom_range(9) < 8) ? ACCENT_CODES[$urandom_range(21)]
                                       : 8'($urandom_range(255));
        add_byte(code);
        if (code == "A" || code == "B" || code == "C" || code == "H" || code == "K") begin
          add_byte(($urandom_range(3) != 0) ? LETTERS[$urandom_range(11)]
                                            : 8'($urandom_range(255)));
        end
      end else if (pick < 75) begin
        add_byte(CH_ESC);
        repeat ($urandom_range(3)) add_byte($urandom_range(1) ? CH_SPACE : CH_HASH);
        add_byte(8'($urandom_range(255)));
      end else if (pick < 85) begin
        add_byte(CH_CURSOR);
        repeat (2) add_byte(8'($urandom_range(1, 255)));
      end else if (pick < 90) begin
        add_byte(CH_NUL);
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Sender: bursts of random length, random gaps between them, and now and
  // then a long burst with no gap at all. Valid holds until the transaction.
  task automatic send_text();
    feed_t item;
    int    burst;
    int    gap;
    burst = 0;
    while (text_q.size() > 0) begin
      if (burst == 0) begin
        gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        burst = ($urandom_range(9) == 0) ? 80 : $urandom_range(1, 24);
        repeat (gap) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
      end
      item = text_q.pop_front();
      in_valid  <= 1'b1;
      char_code <= item.code;
      cur_row   <= item;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: phases of random length, each either always ready, coin-flip
  // ready, or a periodic stall set by rx_hold in every period.
  int rx_phase_left = 0;
  int rx_style      = 0;
  int rx_period     = 4;
  int rx_hold       = 1;
  int rx_tick       = 0;

  always @(negedge clk) begin
    if (!rst) begin
      rx_tick <= rx_tick + 1;
      if (rx_phase_left == 0) begin
        rx_style      <= $urandom_range(2);
        rx_period     <= $urandom_range(2, 12);
        rx_hold       <= $urandom_range(1, 11);
        rx_phase_left <= $urandom_range(50, 300);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(1));
        default: out_ready <= (rx_tick % rx_period) >= (rx_hold % rx_period);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Scoreboard: inputs are predicted before outputs are checked in the same
  // edge, so even a combinational path would find its expectation waiting.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : score
    latin_out_t got;
    latin_out_t want;
    logic [7:0] o0;
    logic [7:0] o1;
    int         n;
    if (!rst) begin
      if (in_valid && in_ready) begin
        n = to_latin1(char_code, o0, o1);
        if (cur_row.typed) begin
          latin_due.push_back({cur_row.exp_ch, 1'b1, cur_row.exp_end});
        end else begin
          if (n >= 1) latin_due.push_back({o0, n == 1, char_code == CH_NUL});
          if (n == 2) latin_due.push_back({o1, 1'b1, 1'b0});
        end
      end
      if (out_valid && out_ready) begin
        got = {out_byte, run_last, text_end};
        if (latin_due.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, got out_byte %h", $time,
                   out_byte);
          errors++;
        end else begin
          want = latin_due.pop_front();
          if (got.ch !== want.ch) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.ch, got.ch);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: run_last expected %b, got %b", $time, want.last, got.last);
            errors++;
          end
          if (got.term !== want.term) begin
            $display("%0t: text_end expected %b, got %b", $time, want.term, got.term);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    for (int i = 0; i < OPENING_ROWS; i++) text_q.push_back(OPENING[i]);
    queue_random_text(RAND_ITEMS);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        send_text();
        while (latin_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);  // catch anything extra
      end
      begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: timeout, %0d results still owed", $time, latin_due.size());
        errors++;
      end
    join_any

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/atl1_pkg.sv
sv/accent_text_to_latin1_unit.sv
tb/sv/accent_text_to_latin1_unit_test.sv
